// ===== rtl/hqs_pkg.sv =====
// shared types, constants and the pixel address scramble for the quarter-scan frame engine
// no dependencies; imported by every module of the block

package hqs_pkg;

    localparam int PANEL_PIXELS   = 128;
    localparam int PANEL_ROWS     = 16;
    localparam int MODULES_ACROSS = 1;
    localparam int CHANNELS       = 2;
    localparam int LINE_PIXELS    = 16;
    localparam int GRP_SLOTS      = 16;
    localparam int CHAN_SPAN      = PANEL_PIXELS / CHANNELS;

    localparam int ADDR_W = $clog2(PANEL_PIXELS);
    localparam int BASE_W = ADDR_W + 1;
    localparam int LPIX_W = $clog2(LINE_PIXELS);
    localparam int SCR_W  = 16;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_SCAN  = 1'b1;

    typedef logic [2:0] color_t;

    typedef struct packed {
        logic       req_type;
        logic [6:0] pixel_index;
        logic [2:0] pixel_color;
        logic [1:0] scan_line;
    } in_item_t;

    typedef struct packed {
        logic [1:0] row_select;
        logic       upper_red;
        logic       upper_green;
        logic       upper_blue;
        logic       lower_red;
        logic       lower_green;
        logic       lower_blue;
        logic       last_of_line;
    } out_item_t;

    // read request for both channels, issued by the scan sequencer
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] up_addr;
        logic              up_ok;
        logic [ADDR_W-1:0] lo_addr;
        logic              lo_ok;
    } rd_req_t;

    // linear map index to panel slot address
    function automatic logic [SCR_W-1:0] scramble(input logic [6:0] idx);
        logic [SCR_W-1:0] row;
        logic [SCR_W-1:0] col;
        logic [SCR_W-1:0] c4;
        logic [SCR_W-1:0] grp;
        logic [SCR_W-1:0] off;
        row = SCR_W'(idx) / SCR_W'(PANEL_ROWS);
        col = SCR_W'(idx) % SCR_W'(PANEL_ROWS);
        c4  = col % SCR_W'(4);
        grp = col / SCR_W'(4) + (row / SCR_W'(4)) * SCR_W'(MODULES_ACROSS * 4);
        case (row[1:0])
            2'd0: off = SCR_W'(2) * (SCR_W'(3) - c4);
            2'd1: off = SCR_W'(2) * (SCR_W'(3) - c4) + SCR_W'(1);
            2'd2: off = SCR_W'(2) * c4 + SCR_W'(9);
            default: off = SCR_W'(2) * c4 + SCR_W'(8);
        endcase
        return grp * SCR_W'(GRP_SLOTS) + off;
    endfunction

endpackage

// ===== rtl/hqs_frame_store.sv =====
// frame store: one write port, two registered read ports, per-entry valid bits
// depends on hqs_pkg

module hqs_frame_store
    import hqs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  color_t            wr_color,
    input  rd_req_t           rd_req,
    output color_t            up_data,
    output color_t            lo_data
);

    color_t                  mem [PANEL_PIXELS];
    logic [PANEL_PIXELS-1:0] valid_reg;
    color_t                  up_data_reg;
    color_t                  lo_data_reg;

    // an entry never written reads as blank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_color;
        end
    end

    // writes are only taken while no line is being read, so no bypass is needed
    always_ff @(posedge aclk) begin
        if (rd_req.en) begin
            up_data_reg <= (rd_req.up_ok && valid_reg[rd_req.up_addr]) ?
                           mem[rd_req.up_addr] : '0;
            lo_data_reg <= (rd_req.lo_ok && valid_reg[rd_req.lo_addr]) ?
                           mem[rd_req.lo_addr] : '0;
        end
    end

    assign up_data = up_data_reg;
    assign lo_data = lo_data_reg;

endmodule

// ===== rtl/hqs_scan_seq.sv =====
// scan sequencer: steps the shift clock counter, issues store reads, holds the result register
// depends on hqs_pkg

module hqs_scan_seq
    import hqs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      start,
    input  logic [1:0] start_line,
    output logic      busy,
    output rd_req_t   rd_req,
    input  color_t    up_data,
    input  color_t    lo_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    localparam logic [LPIX_W-1:0] LAST_POS = LPIX_W'(LINE_PIXELS - 1);

    state_t            state_reg;
    logic [1:0]        line_reg;
    logic [LPIX_W-1:0] pos_reg;
    logic              rd_valid_reg;
    logic              rd_last_reg;
    logic [1:0]        rd_line_reg;
    logic              out_valid_reg;
    out_item_t         out_item_reg;

    logic              adv;
    logic              issue;
    logic [BASE_W-1:0] up_base;
    logic [BASE_W-1:0] lo_base;

    // store output register moves on when the result register is free or being taken
    assign adv   = rd_valid_reg && (!out_valid_reg || m_ready);
    assign issue = (state_reg == ST_RUN) && (!rd_valid_reg || adv);

    assign up_base = BASE_W'(line_reg) * BASE_W'(LINE_PIXELS) + BASE_W'(pos_reg);
    assign lo_base = up_base + BASE_W'(CHAN_SPAN);

    always_comb begin
        rd_req.en      = issue;
        rd_req.up_addr = up_base[ADDR_W-1:0];
        rd_req.up_ok   = up_base < BASE_W'(PANEL_PIXELS);
        rd_req.lo_addr = lo_base[ADDR_W-1:0];
        rd_req.lo_ok   = (CHANNELS > 1) && (lo_base < BASE_W'(PANEL_PIXELS));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        line_reg  <= start_line;
                        pos_reg   <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (issue) begin
                        pos_reg <= pos_reg + LPIX_W'(1);
                        if (pos_reg == LAST_POS) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (issue) begin
                rd_valid_reg <= 1'b1;
                rd_last_reg  <= (pos_reg == LAST_POS);
                rd_line_reg  <= line_reg;
            end else if (adv) begin
                rd_valid_reg <= 1'b0;
            end

            if (adv) begin
                out_valid_reg             <= 1'b1;
                out_item_reg.row_select   <= rd_line_reg;
                out_item_reg.upper_red    <= up_data[0];
                out_item_reg.upper_green  <= up_data[1];
                out_item_reg.upper_blue   <= up_data[2];
                out_item_reg.lower_red    <= lo_data[0];
                out_item_reg.lower_green  <= lo_data[1];
                out_item_reg.lower_blue   <= lo_data[2];
                out_item_reg.last_of_line <= rd_last_reg;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign busy    = (state_reg == ST_RUN);
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

// ===== rtl/hub75_quarter_scan_frame_engine.sv =====
// top level of the quarter-scan frame engine: request decode, pixel write path
// depends on hqs_pkg, hqs_frame_store, hqs_scan_seq
//
//   channel   direction  payload     handshake
//   s_        in         in_item_t   s_valid / s_ready
//   m_        out        out_item_t  m_valid / m_ready
//
// a pixel write request produces no result
// a scan request occupies the sequencer for one line, one store read of both
// channels per shift clock; the first result passes the run state, store output register
// and result register; the store port reads one pixel pair per cycle unless stalled
// reset clears the per-pixel valid bits at once, so the panel reads blank straight away
// a stalled result register holds the sequencer; requests wait while a line is read

module hub75_quarter_scan_frame_engine
    import hqs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic             busy;
    logic             accept;
    logic             start;
    logic [SCR_W-1:0] scr_addr;
    logic             wr_en;
    rd_req_t          rd_req;
    color_t           up_data;
    color_t           lo_data;

    assign s_ready = !busy;
    assign accept  = s_valid && s_ready;
    assign start   = accept && (s_item.req_type == REQ_SCAN);

    assign scr_addr = scramble(s_item.pixel_index);
    assign wr_en    = accept && (s_item.req_type == REQ_WRITE)
                      && (SCR_W'(s_item.pixel_index) < SCR_W'(PANEL_PIXELS))
                      && (scr_addr < SCR_W'(PANEL_PIXELS));

    hqs_frame_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_addr  (scr_addr[ADDR_W-1:0]),
        .wr_color (s_item.pixel_color),
        .rd_req   (rd_req),
        .up_data  (up_data),
        .lo_data  (lo_data)
    );

    hqs_scan_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .start_line (s_item.scan_line),
        .busy       (busy),
        .rd_req     (rd_req),
        .up_data    (up_data),
        .lo_data    (lo_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule
